// ===== design/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types, constants and the rotate function of the stream hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

	localparam logic [1:0] ACT_APPEND = 2'd0;
	localparam logic [1:0] ACT_APPEND_FIN = 2'd1;
	localparam logic [1:0] ACT_FINISH = 2'd2;
	localparam logic [1:0] ACT_RESERVED = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic put_byte;    // write data byte at current position, bump count
		logic put_pad;     // write padding byte (0x80 at first, then zero)
		logic put_len;     // write bit length into words 14 and 15
		logic clr_pad;     // restart padding with the 0x80 byte
		logic start;       // load schedule and working variables
		logic round;       // run one round
		logic fold;        // add working variables into chaining value
		logic emit_load;   // unused; the controller's out_load latches the digest
		logic reinit;      // reload initial hash, clear count
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [5:0] pos;      // byte position of the next data byte
		logic [5:0] pad_pos;  // byte position of the next padding byte
		logic       last_round;
	} sts_t;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
		32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
		32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
		32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
		32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
		32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
		32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
		32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
		32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	localparam logic [31:0] INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS = 6'd56;

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		ror = (x >> n) | (x << (32 - n));
	endfunction

endpackage

// ===== design/sha_datapath.sv =====
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block buffer, byte count, schedule window, round logic and chaining value.
// ----------------------------------------------------------------------------
module sha_datapath import sha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	input  logic [7:0]  data_byte,
	output sts_t        sts,
	output logic [31:0] cv_word [8]
);

	logic [31:0] blk_q [16];
	logic [31:0] win_q [16];
	logic [31:0] v_q [8];
	logic [31:0] cv_q [8];
	logic [60:0] cnt_q;
	logic [5:0]  ppos_q;
	logic        pfirst_q;
	logic [5:0]  rnd_q;

	logic [5:0]  wpos;
	logic [7:0]  wbyte;
	logic [31:0] w15, w2, s0, s1, wnew, wcur, t1, t2;
	logic [31:0] e, a;
	logic [63:0] bits;

	assign sts.pos = cnt_q[5:0];
	assign sts.pad_pos = ppos_q;
	assign sts.last_round = (rnd_q == 6'd63);
	assign wpos = cmd.put_pad ? ppos_q : cnt_q[5:0];
	assign wbyte = cmd.put_pad ? (pfirst_q ? PAD_BYTE : 8'h00) : data_byte;
	assign bits = {cnt_q, 3'b000};

	// The window shifts each round, so slot 0 is always the current word.
	assign w15 = win_q[1];
	assign w2 = win_q[14];
	assign s0 = ror(w15, 7) ^ ror(w15, 18) ^ (w15 >> 3);
	assign s1 = ror(w2, 17) ^ ror(w2, 19) ^ (w2 >> 10);
	assign wnew = win_q[0] + s0 + win_q[9] + s1;
	assign wcur = win_q[0];
	assign e = v_q[4];
	assign a = v_q[0];
	assign t1 = v_q[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25))
		+ ((e & v_q[5]) ^ (~e & v_q[6])) + ROUND_K[rnd_q] + wcur;
	assign t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22))
		+ ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));

	always_comb begin
		for (int j = 0; j < 8; j++) cv_word[j] = cv_q[j];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ppos_q <= '0;
			pfirst_q <= 1'b0;
			rnd_q <= '0;
			for (int j = 0; j < 8; j++) cv_q[j] <= INIT_HASH[j];
		end else begin
			if (cmd.put_byte) cnt_q <= cnt_q + 61'd1;
			if (cmd.clr_pad) begin
				// Padding starts just after the byte written in the same cycle.
				ppos_q <= cnt_q[5:0] + {5'd0, cmd.put_byte};
				pfirst_q <= 1'b1;
			end else if (cmd.put_pad) begin
				ppos_q <= ppos_q + 6'd1;
				pfirst_q <= 1'b0;
			end
			if (cmd.start) rnd_q <= '0;
			else if (cmd.round) rnd_q <= rnd_q + 6'd1;
			if (cmd.fold) begin
				for (int j = 0; j < 8; j++) cv_q[j] <= cv_q[j] + v_q[j];
			end
			if (cmd.reinit) begin
				cnt_q <= '0;
				for (int j = 0; j < 8; j++) cv_q[j] <= INIT_HASH[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.put_byte || cmd.put_pad) begin
			unique case (wpos[1:0])
				2'd0: blk_q[wpos[5:2]] <= {wbyte, 24'h0};
				2'd1: blk_q[wpos[5:2]][23:16] <= wbyte;
				2'd2: blk_q[wpos[5:2]][15:8] <= wbyte;
				default: blk_q[wpos[5:2]][7:0] <= wbyte;
			endcase
		end
		if (cmd.put_len) begin
			blk_q[14] <= bits[63:32];
			blk_q[15] <= bits[31:0];
		end
		if (cmd.start) begin
			for (int j = 0; j < 16; j++) win_q[j] <= blk_q[j];
			for (int j = 0; j < 8; j++) v_q[j] <= cv_q[j];
		end else if (cmd.round) begin
			for (int j = 0; j < 15; j++) win_q[j] <= win_q[j + 1];
			win_q[15] <= wnew;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= e;
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= a;
			v_q[0] <= t1 + t2;
		end
	end

endmodule

// ===== design/sha_ctrl.sv =====
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte intake, padding, compression and digest output.
// ----------------------------------------------------------------------------
module sha_ctrl import sha_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] action,
	input  sts_t       sts,
	output cmd_t       cmd,
	output logic       out_load,
	input  logic       out_busy
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_START = 7'b0000010,
		S_ROUND = 7'b0000100,
		S_FOLD  = 7'b0001000,
		S_PAD   = 7'b0010000,
		S_LEN   = 7'b0100000,
		S_EMIT  = 7'b1000000
	} state_t;

	state_t st_q, st_d;
	logic   fin_q, fin_d;   // finish pending after this compression
	logic   final_q, final_d; // this compression is the final one
	logic   acc;

	assign in_ready = (st_q == S_IDLE);
	assign acc = in_valid && in_ready && (action != ACT_RESERVED);

	always_comb begin
		st_d = st_q;
		fin_d = fin_q;
		final_d = final_q;
		cmd = '0;
		out_load = 1'b0;
		unique case (st_q)
			S_IDLE: begin
				if (acc) begin
					fin_d = (action != ACT_APPEND);
					final_d = 1'b0;
					cmd.clr_pad = fin_d;
					if (action != ACT_FINISH) begin
						cmd.put_byte = 1'b1;
						if (sts.pos == 6'd63) st_d = S_START;
						else if (fin_d) st_d = S_PAD;
					end else begin
						st_d = S_PAD;
					end
				end
			end
			S_START: begin
				cmd.start = 1'b1;
				st_d = S_ROUND;
			end
			S_ROUND: begin
				cmd.round = 1'b1;
				if (sts.last_round) st_d = S_FOLD;
			end
			S_FOLD: begin
				cmd.fold = 1'b1;
				if (final_q) st_d = S_EMIT;
				else if (fin_q) st_d = S_PAD;
				else st_d = S_IDLE;
			end
			S_PAD: begin
				cmd.put_pad = 1'b1;
				if (sts.pad_pos == LEN_POS - 6'd1 && !final_q) begin
					st_d = S_LEN;
				end else if (sts.pad_pos == 6'd63) begin
					// Tail too long for the length: compress and pad again.
					st_d = S_START;
				end
			end
			S_LEN: begin
				cmd.put_len = 1'b1;
				final_d = 1'b1;
				st_d = S_START;
			end
			S_EMIT: begin
				if (!out_busy) begin
					out_load = 1'b1;
					cmd.reinit = 1'b1;
					fin_d = 1'b0;
					final_d = 1'b0;
					st_d = S_IDLE;
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			fin_q <= 1'b0;
			final_q <= 1'b0;
		end else begin
			st_q <= st_d;
			fin_q <= fin_d;
			final_q <= final_d;
		end
	end

`ifndef SYNTHESIS
	a_one_hot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(st_q))
		else $error("state not one-hot");
	a_emit_final: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_EMIT) |-> final_q)
		else $error("emit without final block");
	a_round_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_ROUND && sts.last_round) |=> (st_q == S_FOLD))
		else $error("round count overrun");
`endif

endmodule

// ===== design/sha_out.sv =====
// ----------------------------------------------------------------------------
// SHA-256 digest output
// Holds the digest and delivers it one word per handshake.
// ----------------------------------------------------------------------------
module sha_out import sha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  logic [31:0] cv_word [8],
	output logic        busy,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	logic [31:0] dig_q [8];
	logic [2:0]  idx_q;
	logic        vld_q;

	assign busy = vld_q;
	assign out_valid = vld_q;
	assign digest_word = dig_q[idx_q];
	assign word_index = idx_q;
	assign last_word = (idx_q == 3'd7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			vld_q <= 1'b1;
			idx_q <= '0;
		end else if (vld_q && out_ready) begin
			idx_q <= idx_q + 3'd1;
			if (idx_q == 3'd7) vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int j = 0; j < 8; j++) dig_q[j] <= cv_word[j];
		end
	end

endmodule

// ===== design/sha256_stream_hasher_top.sv =====
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Hashes a byte stream and returns the eight digest words on finish.
// ----------------------------------------------------------------------------
// Channel  Handshake              Payload
// in       in_valid / in_ready    action, data_byte
// out      out_valid / out_ready  digest_word, word_index, last_word
//
// Each appended byte goes into the block buffer; the 64th byte of a block then
// triggers the schedule load, 64 rounds and the fold into the hash.
// A finish pads one byte per cycle up to the length field, then compresses
// one or two blocks before the digest is loaded for output.
// Reset loads the initial hash values and clears the byte count.
// The digest drains one word per accepted handshake while the next message
// streams in; a new digest waits until the previous one has drained.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_top import sha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	cmd_t        cmd;
	sts_t        sts;
	logic [31:0] cv_word [8];
	logic        out_load;
	logic        out_busy;

	// The controller steps the datapath through intake, padding and rounds.
	sha_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.action(action), .sts(sts), .cmd(cmd), .out_load(out_load),
		.out_busy(out_busy)
	);

	sha_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .data_byte(data_byte),
		.sts(sts), .cv_word(cv_word)
	);

	// The output register holds the digest, so hashing may carry on.
	sha_out u_out (
		.clk(clk), .arst_n(arst_n), .load(out_load), .cv_word(cv_word),
		.busy(out_busy), .out_valid(out_valid), .out_ready(out_ready),
		.digest_word(digest_word), .word_index(word_index), .last_word(last_word)
	);

endmodule
